// ===== rtl/tbi_pkg.sv =====
// tbi_pkg: shared types and constants for the table bilinear interpolator
// no dependencies
`timescale 1ns / 1ps

package tbi_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 8;
    localparam int VALUE_BITS = 16;
    localparam int ROW_BITS   = 4;
    localparam int COL_BITS   = 3;
    localparam int FRAC_BITS  = 17;
    localparam int ACC_BITS   = 48;

    localparam logic [1:0] ACT_GRID   = 2'd0;
    localparam logic [1:0] ACT_ROW_BP = 2'd1;
    localparam logic [1:0] ACT_COL_BP = 2'd2;
    localparam logic [1:0] ACT_INTERP = 2'd3;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    localparam logic [4:0] ROWS_RESET = 5'd11;
    localparam logic [3:0] COLS_RESET = 4'd6;

    localparam logic [FRAC_BITS-1:0] FRAC_ONE = 17'h10000;

    typedef struct packed {
        logic [1:0]            action;
        logic [ROW_BITS-1:0]   row_index;
        logic [COL_BITS-1:0]   col_index;
        logic [VALUE_BITS-1:0] load_value;
        logic [VALUE_BITS-1:0] query_row;
        logic [VALUE_BITS-1:0] query_col;
    } in_word_t;

    typedef struct packed {
        logic [VALUE_BITS-1:0] blended_value;
        logic                  out_of_range;
    } out_word_t;

endpackage

// ===== rtl/tbi_div.sv =====
// tbi_div: restoring divider, one quotient bit per cycle
// 32-bit dividend over 16-bit divisor, quotient known to fit 17 bits; uses tbi_pkg
`timescale 1ns / 1ps

module tbi_div
    import tbi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [31:0]           num,
    input  logic [15:0]           den,
    output logic                  done,
    output logic [FRAC_BITS-1:0]  quo
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [15:0] rem_reg, rem_next;
    logic [31:0] num_reg, num_next;
    logic [15:0] den_reg, den_next;
    logic [16:0] trial;
    logic [16:0] diff;
    logic        ge;

    assign trial = {rem_reg, num_reg[31]};
    assign ge    = trial >= {1'b0, den_reg};
    assign diff  = trial - {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = 5'd0;
            rem_next  = 16'd0;
            num_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            // quotient bits shift in behind the dividend
            rem_next = ge ? diff[15:0] : trial[15:0];
            num_next = {num_reg[30:0], ge};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        num_reg <= num_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = num_reg[FRAC_BITS-1:0];

endmodule

// ===== rtl/table_bilinear_interpolator.sv =====
// table_bilinear_interpolator: top level with grid and breakpoint memories and sequencer
// uses tbi_pkg and tbi_div
`timescale 1ns / 1ps

// Load words (grid entry, row breakpoint, column breakpoint) are written in the cycle they
// are accepted and give no result. An interpolate word runs alone: the row list, then the
// column list, is scanned one breakpoint at a time through the one-port memories (a read
// state, then a check state), each bracketed fraction takes a serial division (skipped for a
// zero-width interval), and the four corners are each weighted, then read and accumulated.
// An out-of-range query ends at the scan.
// The result sits in an output register, and the block takes new words while it waits;
// the next result holds the sequencer in its done state until that register is free.

module table_bilinear_interpolator
    import tbi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_word_t   in_word,
    output logic       out_valid,
    input  logic       out_ready,
    output out_word_t  out_word
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_CHK  = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WT   = 3'd4;
    localparam logic [2:0] S_MAC  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [VALUE_BITS-1:0] grid_mem [MAX_ROWS*MAX_COLS];
    logic [VALUE_BITS-1:0] row_mem  [MAX_ROWS];
    logic [VALUE_BITS-1:0] col_mem  [MAX_COLS];
    logic [VALUE_BITS-1:0] grid_rd_reg, row_rd_reg, col_rd_reg;

    logic [4:0]            rows_reg;
    logic [3:0]            cols_reg;
    logic [2:0]            state_reg;
    logic                  col_phase_reg;
    logic [ROW_BITS-1:0]   idx_reg;
    logic [VALUE_BITS-1:0] prev_reg;
    logic [VALUE_BITS-1:0] qr_reg, qc_reg;
    logic [ROW_BITS-1:0]   j_reg;
    logic [COL_BITS-1:0]   k_reg;
    logic [FRAC_BITS-1:0]  fr_reg, fc_reg;
    logic [1:0]            corner_reg;
    logic [32:0]           weight_reg;
    logic [ACC_BITS-1:0]   acc_reg;
    logic                  oor_reg;
    logic                  out_valid_reg;
    out_word_t             out_word_reg;

    logic                  accept;
    logic [4:0]            n_m1;
    logic [VALUE_BITS-1:0] cur, x;
    logic                  hit;
    logic [VALUE_BITS-1:0] span, offs;
    logic                  div_start, div_done;
    logic [FRAC_BITS-1:0]  div_quo;
    logic [ROW_BITS-1:0]   g_row;
    logic [COL_BITS-1:0]   g_col;
    logic [FRAC_BITS-1:0]  w_a, w_b;
    logic [33:0]           w_prod;
    logic [48:0]           mac_prod;
    logic [ACC_BITS-1:0]   acc_round;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    // clamp counts into 2..max
    always_comb
    begin
        if (col_phase_reg)
        begin
            if (cols_reg < 4'd2)
                n_m1 = 5'd1;
            else if (cols_reg > 4'd8)
                n_m1 = 5'd7;
            else
                n_m1 = {1'b0, cols_reg - 4'd1};
        end
        else
        begin
            if (rows_reg < 5'd2)
                n_m1 = 5'd1;
            else if (rows_reg > 5'd16)
                n_m1 = 5'd15;
            else
                n_m1 = rows_reg - 5'd1;
        end
    end

    assign cur  = col_phase_reg ? col_rd_reg : row_rd_reg;
    assign x    = col_phase_reg ? qc_reg : qr_reg;
    assign hit  = (idx_reg != '0) && (prev_reg <= x) && (x <= cur);
    assign span = cur - prev_reg;
    assign offs = x - prev_reg;
    assign div_start = (state_reg == S_CHK) && hit && (span != '0);

    tbi_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   ({offs, 16'd0}),
        .den   (span),
        .done  (div_done),
        .quo   (div_quo)
    );

    // corner order: (j,k), (j+1,k), (j+1,k+1), (j,k+1)
    always_comb
    begin
        g_row = (corner_reg == 2'd1 || corner_reg == 2'd2) ? j_reg + 4'd1 : j_reg;
        g_col = (corner_reg == 2'd2 || corner_reg == 2'd3) ? k_reg + 3'd1 : k_reg;
        w_a   = (corner_reg == 2'd1 || corner_reg == 2'd2) ? fr_reg : FRAC_ONE - fr_reg;
        w_b   = (corner_reg == 2'd2 || corner_reg == 2'd3) ? fc_reg : FRAC_ONE - fc_reg;
    end

    assign w_prod    = w_a * w_b;
    assign mac_prod  = weight_reg * grid_rd_reg;
    assign acc_round = acc_reg + 48'h0000_8000_0000;

    // memories
    always_ff @(posedge clk)
    begin
        if (accept && in_word.action == ACT_GRID)
            grid_mem[{in_word.row_index, in_word.col_index}] <= in_word.load_value;
        if (accept && in_word.action == ACT_ROW_BP)
            row_mem[in_word.row_index] <= in_word.load_value;
        if (accept && in_word.action == ACT_COL_BP)
            col_mem[in_word.col_index] <= in_word.load_value;
        grid_rd_reg <= grid_mem[{g_row, g_col}];
        row_rd_reg  <= row_mem[idx_reg];
        col_rd_reg  <= col_mem[idx_reg[COL_BITS-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg      <= ROWS_RESET;
            cols_reg      <= COLS_RESET;
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_ROWS: rows_reg <= cfg_data;
                    CFG_COLS: cols_reg <= cfg_data[3:0];
                    default:  rows_reg <= rows_reg;
                endcase
            end
            // the done state refills the output register itself
            if (out_valid_reg && out_ready && state_reg != S_DONE)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && in_word.action == ACT_INTERP)
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (hit)
                    begin
                        if (span != '0)
                            state_reg <= S_DIV;
                        else if (col_phase_reg)
                            state_reg <= S_WT;
                        else
                            state_reg <= S_RD;
                    end
                    else if ({1'b0, idx_reg} == n_m1)
                        state_reg <= S_DONE;
                    else
                        state_reg <= S_RD;
                end
                S_DIV:
                begin
                    if (div_done)
                        state_reg <= col_phase_reg ? S_WT : S_RD;
                end
                S_WT:
                begin
                    state_reg <= S_MAC;
                end
                S_MAC:
                begin
                    state_reg <= (corner_reg == 2'd3) ? S_DONE : S_WT;
                end
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                qr_reg        <= in_word.query_row;
                qc_reg        <= in_word.query_col;
                idx_reg       <= '0;
                col_phase_reg <= 1'b0;
                acc_reg       <= '0;
                corner_reg    <= 2'd0;
                oor_reg       <= 1'b0;
            end
            S_CHK:
            begin
                if (hit)
                begin
                    if (col_phase_reg)
                    begin
                        k_reg  <= idx_reg[COL_BITS-1:0] - 3'd1;
                        fc_reg <= '0;
                    end
                    else
                    begin
                        j_reg  <= idx_reg - 4'd1;
                        fr_reg <= '0;
                        if (span == '0)
                        begin
                            col_phase_reg <= 1'b1;
                            idx_reg       <= '0;
                        end
                    end
                end
                else if ({1'b0, idx_reg} == n_m1)
                    oor_reg <= 1'b1;
                else
                begin
                    prev_reg <= cur;
                    idx_reg  <= idx_reg + 4'd1;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    if (col_phase_reg)
                        fc_reg <= div_quo;
                    else
                    begin
                        fr_reg        <= div_quo;
                        col_phase_reg <= 1'b1;
                        idx_reg       <= '0;
                    end
                end
            end
            S_WT:
            begin
                weight_reg <= w_prod[32:0];
            end
            S_MAC:
            begin
                acc_reg    <= acc_reg + mac_prod[ACC_BITS-1:0];
                corner_reg <= corner_reg + 2'd1;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_word_reg.blended_value <= acc_round[47:32];
                    out_word_reg.out_of_range  <= oor_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

endmodule

// ===== verif/tbi_checker.sv =====
// tbi_checker: watches both channels of the table bilinear interpolator,
// predicts each interpolation result and compares it; depends on tbi_pkg
`timescale 1ns / 1ps

module tbi_checker
    import tbi_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [4:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_ready,
    input  in_word_t   in_word,
    input  logic       out_valid,
    input  logic       out_ready,
    input  out_word_t  out_word,
    output int         fail_count,
    output int         pending
);

    logic [4:0]            rows_reg;
    logic [3:0]            cols_reg;
    logic [VALUE_BITS-1:0] grid_mem [MAX_ROWS*MAX_COLS];
    logic [VALUE_BITS-1:0] row_bp [MAX_ROWS];
    logic [VALUE_BITS-1:0] col_bp [MAX_COLS];
    out_word_t             blend_queue [$];

    assign pending = blend_queue.size();

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    function automatic int clamp_count(input int v, input int maxv);
        if (v < 2)
            return 2;
        if (v > maxv)
            return maxv;
        return v;
    endfunction

    // first interval lo <= x <= hi; fraction in 0..65536
    function automatic bit find_bracket(input logic [VALUE_BITS-1:0] bp [],
                                        input int n, input logic [15:0] x,
                                        output int idx, output logic [63:0] frac);
        logic [63:0] lo;
        logic [63:0] hi;
        for (int i = 0; i + 1 < n; i++)
        begin
            lo = bp[i];
            hi = bp[i+1];
            if (x >= lo && x <= hi)
            begin
                idx = i;
                frac = (hi == lo) ? 64'd0 : ((x - lo) << 16) / (hi - lo);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic out_word_t blend_point(input logic [15:0] qr, input logic [15:0] qc);
        out_word_t   res;
        int          j;
        int          k;
        logic [63:0] fr;
        logic [63:0] fc;
        logic [63:0] s;
        logic [VALUE_BITS-1:0] rb [];
        logic [VALUE_BITS-1:0] cb [];
        rb = new[MAX_ROWS];
        cb = new[MAX_COLS];
        foreach (rb[i]) rb[i] = row_bp[i];
        foreach (cb[i]) cb[i] = col_bp[i];
        if (!find_bracket(rb, clamp_count(rows_reg, MAX_ROWS), qr, j, fr) ||
            !find_bracket(cb, clamp_count(cols_reg, MAX_COLS), qc, k, fc))
        begin
            res.blended_value = '0;
            res.out_of_range = 1'b1;
            return res;
        end
        s = (64'd65536 - fr) * (64'd65536 - fc) * grid_mem[j*MAX_COLS + k];
        s += fr * (64'd65536 - fc) * grid_mem[(j+1)*MAX_COLS + k];
        s += fr * fc * grid_mem[(j+1)*MAX_COLS + k + 1];
        s += (64'd65536 - fr) * fc * grid_mem[j*MAX_COLS + k + 1];
        s = (s + (64'd1 << 31)) >> 32;
        res.blended_value = s[VALUE_BITS-1:0];
        res.out_of_range = 1'b0;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            rows_reg <= ROWS_RESET;
            cols_reg <= COLS_RESET;
            fail_count = 0;
            blend_queue.delete();
            foreach (grid_mem[i]) grid_mem[i] = '0;
            foreach (row_bp[i]) row_bp[i] = '0;
            foreach (col_bp[i]) col_bp[i] = '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROWS)
                    rows_reg <= cfg_data;
                else
                    cols_reg <= cfg_data[3:0];
            end
            if (in_valid && in_ready)
            begin
                case (in_word.action)
                    ACT_GRID:   grid_mem[in_word.row_index*MAX_COLS + in_word.col_index] =
                                    in_word.load_value;
                    ACT_ROW_BP: row_bp[in_word.row_index] = in_word.load_value;
                    ACT_COL_BP: col_bp[in_word.col_index] = in_word.load_value;
                    default:    blend_queue.push_back(blend_point(in_word.query_row,
                                                                  in_word.query_col));
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (blend_queue.size() == 0)
                    report_mismatch("unexpected word", out_word.blended_value, -1);
                else
                begin
                    want = blend_queue.pop_front();
                    if (out_word.blended_value !== want.blended_value)
                        report_mismatch("blended_value", out_word.blended_value,
                                        want.blended_value);
                    if (out_word.out_of_range !== want.out_of_range)
                        report_mismatch("out_of_range", out_word.out_of_range,
                                        want.out_of_range);
                end
            end
        end
    end

endmodule

// ===== verif/tb_table_bilinear_interpolator.sv =====
// tb_table_bilinear_interpolator: stimulus, configuration phases and verdict
// depends on tbi_pkg, table_bilinear_interpolator and tbi_checker
`timescale 1ns / 1ps

module tb_table_bilinear_interpolator;
    import tbi_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 200;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_we = 1'b0;
    logic       cfg_index = 1'b0;
    logic [4:0] cfg_data = '0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    in_word_t   in_word = '0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    out_word_t  out_word;
    int         fail_count;
    int         pending;
    int         idle_cycles = 0;
    bit         quiet_mode = 1'b0;
    bit         hold_sink = 1'b0;
    logic [15:0] row_pts [MAX_ROWS];
    logic [15:0] col_pts [MAX_COLS];

    always #5 clk = ~clk;

    table_bilinear_interpolator i_dut (.*);

    tbi_checker i_checker (.*);

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // receiver: random stall bursts, long hold-off on request
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_sink)
            begin
                out_ready <= 1'b0;
                repeat (400) @(posedge clk);
                hold_sink = 1'b0;
            end
            else if (!quiet_mode && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                out_ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // valid stays up between back-to-back words
    task automatic send_word(input in_word_t w);
        if (!quiet_mode && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic load_word(input logic [1:0] act, input int r, input int c,
                             input logic [15:0] v);
        in_word_t w;
        w = '0;
        w.action = act;
        w.row_index = 4'(r);
        w.col_index = 3'(c);
        w.load_value = v;
        w.query_row = 16'($urandom);
        w.query_col = 16'($urandom);
        send_word(w);
    endtask

    task automatic query_word(input logic [15:0] qr, input logic [15:0] qc);
        in_word_t w;
        w = '0;
        w.row_index = 4'($urandom);
        w.col_index = 3'($urandom);
        w.load_value = 16'($urandom);
        w.action = ACT_INTERP;
        w.query_row = qr;
        w.query_col = qc;
        send_word(w);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic idx, input logic [4:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // rising breakpoints with some repeats so zero-width intervals appear
    task automatic load_table(input bit full_range, input bit with_grid);
        int acc;
        acc = 0;
        for (int i = 0; i < MAX_ROWS; i++)
        begin
            row_pts[i] = full_range ? ((i == MAX_ROWS - 1) ? 16'hffff : 16'(i * 4000))
                                    : 16'(acc);
            acc += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 4000);
            load_word(ACT_ROW_BP, i, $urandom_range(0, 7), row_pts[i]);
        end
        acc = 0;
        for (int i = 0; i < MAX_COLS; i++)
        begin
            col_pts[i] = full_range ? ((i == MAX_COLS - 1) ? 16'hffff : 16'(i * 9000))
                                    : 16'(acc);
            acc += ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 9000);
            load_word(ACT_COL_BP, $urandom_range(0, 15), i, col_pts[i]);
        end
        if (with_grid)
            for (int r = 0; r < MAX_ROWS; r++)
                for (int c = 0; c < MAX_COLS; c++)
                    load_word(ACT_GRID, r, c,
                              ($urandom_range(0, 5) == 0) ? 16'hffff : 16'($urandom));
    endtask

    task automatic random_query(input int nr, input int nc);
        logic [15:0] qr;
        logic [15:0] qc;
        if ($urandom_range(0, 7) == 0)
        begin
            qr = 16'($urandom);
            qc = 16'($urandom);
        end
        else
        begin
            qr = 16'($urandom_range(row_pts[0], row_pts[nr-1]));
            qc = 16'($urandom_range(col_pts[0], col_pts[nc-1]));
            if ($urandom_range(0, 9) == 0)
                qr = row_pts[$urandom_range(0, nr - 1)];
            if ($urandom_range(0, 9) == 0)
                qc = col_pts[$urandom_range(0, nc - 1)];
        end
        query_word(qr, qc);
    endtask

    initial
    begin
        int settings [6][2];
        int nr;
        int nc;
        settings = '{'{11, 6}, '{2, 2}, '{16, 8}, '{0, 15}, '{31, 1}, '{7, 5}};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: full range table, corner coordinates at reset counts
        load_table(1'b1, 1'b1);
        query_word(16'h0000, 16'h0000);
        query_word(row_pts[10], col_pts[5]);
        query_word(16'hffff, 16'hffff);
        query_word(row_pts[3], col_pts[2] + 16'd1);
        query_word(row_pts[1] + 16'd1, 16'hffff);
        // ignored-free ops with extreme values, then sender waits for all results
        load_word(ACT_GRID, 15, 7, 16'hffff);
        load_word(ACT_GRID, 0, 0, 16'h0000);
        query_word(16'd1, 16'd1);
        wait_drained();
        write_config(CFG_ROWS, 5'd16);
        write_config(CFG_COLS, 5'd8);
        query_word(16'hffff, 16'hffff);
        query_word(16'hfffe, 16'd0);
        // long receiver hold-off while words keep coming
        hold_sink = 1'b1;
        for (int i = 0; i < 10; i++)
            random_query(16, 8);
        wait_drained();

        for (int p = 0; p < 6; p++)
        begin
            write_config(CFG_ROWS, 5'(settings[p][0]));
            write_config(CFG_COLS, 5'(settings[p][1]));
            nr = (settings[p][0] < 2) ? 2 : (settings[p][0] > 16) ? 16 : settings[p][0];
            nc = (settings[p][1] < 2) ? 2 : (settings[p][1] > 8) ? 8 : settings[p][1];
            load_table(1'(p % 2), 1'b0);
            if (p == 5)
                quiet_mode = 1'b1;
            for (int i = 0; i < 75; i++)
            begin
                if ($urandom_range(0, 30) == 0)
                    load_word(ACT_GRID, $urandom_range(0, 15), $urandom_range(0, 7),
                              16'($urandom));
                random_query(nr, nc);
            end
            wait_drained();
        end

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== table_bilinear_interpolator.f =====
rtl/tbi_pkg.sv
rtl/tbi_div.sv
rtl/table_bilinear_interpolator.sv
verif/tbi_checker.sv
verif/tb_table_bilinear_interpolator.sv
